/* design/dcf_single_point_eval_macros.svh */
// ----------------------------------------------------------------------------
// DCF evaluator assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DCF_SINGLE_POINT_EVAL_MACROS_SVH
`define DCF_SINGLE_POINT_EVAL_MACROS_SVH
`ifndef SYNTH
`define DCF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcf assertion failed");
`define DCF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcf assertion failed");
`else
`define DCF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DCF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/dcf_pkg.sv */
// ----------------------------------------------------------------------------
// DCF evaluator package
// Field widths, item kinds and the AES-128 round helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package dcf_pkg;

   localparam int MAX_DEPTH_DEF = 64;
   localparam int KIND_W        = 2;
   localparam int WIDX_W        = 8;
   localparam int HALF_W        = 64;
   localparam int LEVEL_W       = 7;
   localparam int POINT_W       = 64;
   localparam int DEPTH_W       = 7;
   localparam int SHARE_W       = 8;
   localparam int DEPTH_RESET   = 64;
   localparam int AES_ROUNDS    = 10;

   localparam logic [KIND_W-1:0] KIND_LOAD_WORD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_BIT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EVAL      = 2'd2;

   typedef logic [127:0] block_type;
   typedef logic [7:0] sbox_type [0:255];
   typedef logic [7:0] rcon_type [0:9];

   localparam sbox_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam rcon_type RCON = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // multiply by x in GF(2^8)
   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte substitution followed by row shift
   function automatic block_type sub_shift(input block_type s);
      block_type r;
      r = '0;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            r[8*(k+4*c) +: 8] = SBOX[s[8*(k+4*((c+k)%4)) +: 8]];
         end
      end
      return r;
   endfunction

   // column mixing
   function automatic block_type mix_cols(input block_type s);
      block_type r;
      logic [7:0] a0, a1, a2, a3, all;
      r = '0;
      for (int c = 0; c < 4; c++) begin
         a0  = s[8*(4*c)   +: 8];
         a1  = s[8*(4*c+1) +: 8];
         a2  = s[8*(4*c+2) +: 8];
         a3  = s[8*(4*c+3) +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         r[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         r[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         r[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         r[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return r;
   endfunction

   // one step of the key schedule; rnd runs 1..10
   function automatic block_type key_next(input block_type rk, input logic [3:0] rnd);
      logic [31:0] t, w0, w1, w2, w3;
      t  = {SBOX[rk[103:96]], SBOX[rk[127:120]], SBOX[rk[119:112]],
            SBOX[rk[111:104]] ^ RCON[rnd - 4'd1]};
      w0 = rk[31:0] ^ t;
      w1 = rk[63:32] ^ w0;
      w2 = rk[95:64] ^ w1;
      w3 = rk[127:96] ^ w2;
      return {w3, w2, w1, w0};
   endfunction

endpackage
`default_nettype wire

/* design/dcf_req_if.sv */
// ----------------------------------------------------------------------------
// DCF request channel
// Valid/ready channel carrying one load or evaluate transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface dcf_req_if;
   import dcf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [WIDX_W-1:0]    word_index;
   logic [HALF_W-1:0]    key_half;
   logic [LEVEL_W-1:0]   level;
   logic                 correction_bit;
   logic [POINT_W-1:0]   point;
   modport source (output valid, kind, word_index, key_half, level, correction_bit, point,
                   input ready);
   modport sink   (input valid, kind, word_index, key_half, level, correction_bit, point,
                   output ready);
endinterface
`default_nettype wire

/* design/dcf_rsp_if.sv */
// ----------------------------------------------------------------------------
// DCF response channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface dcf_rsp_if;
   import dcf_pkg::*;
   logic               valid;
   logic               ready;
   logic [SHARE_W-1:0] share;
   logic               share_valid;
   modport source (output valid, share, share_valid, input ready);
   modport sink   (input valid, share, share_valid, output ready);
endinterface
`default_nettype wire

/* design/dcf_csr_if.sv */
// ----------------------------------------------------------------------------
// DCF configuration channel
// Valid/ready write channel for the tree depth register.
// ----------------------------------------------------------------------------
`default_nettype none
interface dcf_csr_if;
   import dcf_pkg::*;
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] tree_depth;
   modport source (output valid, tree_depth, input ready);
   modport sink   (input valid, tree_depth, output ready);
endinterface
`default_nettype wire

/* design/dcf_single_point_eval.sv */
// ----------------------------------------------------------------------------
// DCF single point evaluator
// Walks a loaded comparison function key down the tree for one query point.
// ----------------------------------------------------------------------------
// Load transactions (key half word, correction bit, or an unused kind)
// answer with share 0, share_valid 0. An evaluate transaction walks a tree
// of depth D (depth clamped to MAX_DEPTH): each level reads its correction
// word from the key memory's single read port as two half words and then
// runs two AES-128 encryptions of ten rounds each through one shared round
// unit. The request channel is not ready while an evaluation runs; the
// result waits in an output register.
`default_nettype none
`include "dcf_single_point_eval_macros.svh"
module dcf_single_point_eval #(
   parameter int MAX_DEPTH = dcf_pkg::MAX_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   dcf_req_if.sink   req_ch,
   dcf_rsp_if.source rsp_ch,
   dcf_csr_if.sink   csr_ch
);
   import dcf_pkg::*;

   localparam int NWORDS = 2 * (MAX_DEPTH + 1);
   localparam int NBITS  = MAX_DEPTH + 1;
   localparam int WAW    = $clog2(NWORDS);
   localparam int LVL_W  = $clog2(NBITS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEED0 = 3'd1;
   localparam logic [2:0] S_SEED1 = 3'd2;
   localparam logic [2:0] S_LVL   = 3'd3;
   localparam logic [2:0] S_CWLO  = 3'd4;
   localparam logic [2:0] S_ENC   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [DEPTH_W-1:0] tree_depth_ff;
   logic [LVL_W-1:0]   depth_ff, depth_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [POINT_W-1:0] point_ff, point_in;
   block_type          seed_ff, seed_in;
   block_type          hash_ff, hash_in;
   block_type          tblk_ff, tblk_in;
   block_type          aes_st_ff, aes_st_in;
   block_type          rk_ff, rk_in;
   logic [3:0]         rnd_ff, rnd_in;
   logic               pass_ff, pass_in;
   logic               keep_ff, keep_in;
   logic [63:0]        cwlo_ff, cwlo_in;
   logic [SHARE_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SHARE_W-1:0] share_ff, share_in;
   logic               share_valid_ff, share_valid_in;

   logic               req_accept;
   logic               word_wr_en, bit_wr_en;
   logic [WAW-1:0]     word_rd_addr;
   logic [LVL_W-1:0]   bit_rd_addr;
   logic [63:0]        word_rd;
   logic               bit_rd;
   block_type          st_next, rk_next;
   block_type          hash_now, vblk, corr;
   logic [LVL_W-1:0]   lvl_p1;
   logic [6:0]         pidx;
   logic               dbit;

   dcf_key_store #(
      .NWORDS (NWORDS),
      .WAW    (WAW),
      .NBITS  (NBITS),
      .BAW    (LVL_W)
   ) u_store (
      .clock        (clock),
      .word_wr_en   (word_wr_en),
      .word_wr_addr (req_ch.word_index[WAW-1:0]),
      .word_wr_data (req_ch.key_half),
      .word_rd_addr (word_rd_addr),
      .word_rd_data (word_rd),
      .bit_wr_en    (bit_wr_en),
      .bit_wr_addr  (req_ch.level[LVL_W-1:0]),
      .bit_wr_data  (req_ch.correction_bit),
      .bit_rd_addr  (bit_rd_addr),
      .bit_rd_data  (bit_rd)
   );

   dcf_aes_round u_round (
      .st_in  (aes_st_ff),
      .rk_in  (rk_ff),
      .rnd    (rnd_ff),
      .st_out (st_next),
      .rk_out (rk_next)
   );

   assign req_accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign csr_ch.ready  = 1'b1;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.share  = share_ff;
   assign rsp_ch.share_valid = share_valid_ff;

   // helpers for the level walk
   assign lvl_p1   = lvl_ff + LVL_W'(1);
   assign pidx     = 7'(depth_ff) - 7'(lvl_ff) - 7'd1;
   assign hash_now = {seed_ff[127:2], 2'b00};
   assign vblk     = st_next ^ hash_ff;
   assign dbit     = keep_ff ? cwlo_ff[0] : cwlo_ff[1];
   assign corr     = seed_ff[0] ? {word_rd, cwlo_ff[63:2], 1'b0, dbit} : '0;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      depth_in       = depth_ff;
      lvl_in         = lvl_ff;
      point_in       = point_ff;
      seed_in        = seed_ff;
      hash_in        = hash_ff;
      tblk_in        = tblk_ff;
      aes_st_in      = aes_st_ff;
      rk_in          = rk_ff;
      rnd_in         = rnd_ff;
      pass_in        = pass_ff;
      keep_in        = keep_ff;
      cwlo_in        = cwlo_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      share_in       = share_ff;
      share_valid_in = share_valid_ff;
      word_wr_en     = 1'b0;
      bit_wr_en      = 1'b0;
      word_rd_addr   = '0;
      bit_rd_addr    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in   = 1'b1;
               share_in       = '0;
               share_valid_in = 1'b0;
               unique case (req_ch.kind)
                  KIND_LOAD_WORD: begin
                     word_wr_en = ({1'b0, req_ch.word_index} < 9'(NWORDS));
                  end
                  KIND_LOAD_BIT: begin
                     bit_wr_en = ({1'b0, req_ch.level} < 8'(NBITS));
                  end
                  KIND_EVAL: begin
                     rsp_valid_in = 1'b0;
                     depth_in = (tree_depth_ff > 7'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH)
                                                              : tree_depth_ff[LVL_W-1:0];
                     point_in = req_ch.point;
                     lvl_in   = '0;
                     acc_in   = '0;
                     state_in = S_SEED0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEED0: begin
            seed_in[63:0] = word_rd;
            word_rd_addr  = WAW'(1);
            state_in      = S_SEED1;
         end
         S_SEED1: begin
            seed_in[127:64] = word_rd;
            state_in        = S_LVL;
         end
         S_LVL: begin
            if (lvl_ff == depth_ff) begin
               bit_rd_addr = depth_ff;
               state_in    = S_FIN;
            end else begin
               word_rd_addr = WAW'({lvl_p1, 1'b0});
               bit_rd_addr  = lvl_ff;
               keep_in      = point_ff[pidx[5:0]];
               state_in     = S_CWLO;
            end
         end
         S_CWLO: begin
            cwlo_in      = word_rd;
            word_rd_addr = WAW'({lvl_p1, 1'b1});
            bit_rd_addr  = lvl_ff;
            hash_in      = hash_now;
            aes_st_in    = hash_now ^ {126'b0, 1'b0, keep_ff};
            rk_in        = {126'b0, 1'b0, keep_ff};
            rnd_in       = 4'd1;
            pass_in      = 1'b0;
            state_in     = S_ENC;
         end
         S_ENC: begin
            // hold the high correction half and the level bit on the read ports
            word_rd_addr = WAW'({lvl_p1, 1'b1});
            bit_rd_addr  = lvl_ff;
            aes_st_in    = st_next;
            rk_in        = rk_next;
            rnd_in       = rnd_ff + 4'd1;
            if (rnd_ff == 4'(AES_ROUNDS)) begin
               if (!pass_ff) begin
                  // seed branch done; start the share branch
                  tblk_in   = vblk;
                  aes_st_in = hash_ff ^ {126'b0, 1'b1, keep_ff};
                  rk_in     = {126'b0, 1'b1, keep_ff};
                  rnd_in    = 4'd1;
                  pass_in   = 1'b1;
               end else begin
                  acc_in   = acc_ff ^ vblk[7:0] ^ {7'b0, seed_ff[0] & bit_rd};
                  seed_in  = tblk_ff ^ corr;
                  lvl_in   = lvl_p1;
                  rnd_in   = 4'd1;
                  state_in = S_LVL;
               end
            end
         end
         S_FIN: begin
            rsp_valid_in   = 1'b1;
            share_in       = acc_ff ^ {seed_ff[7:2], 2'b00} ^ {7'b0, seed_ff[0] & bit_rd};
            share_valid_in = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         tree_depth_ff <= DEPTH_W'(DEPTH_RESET);
         rnd_ff        <= 4'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rnd_ff       <= rnd_in;
         if (csr_ch.valid && csr_ch.ready) begin
            tree_depth_ff <= csr_ch.tree_depth;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      depth_ff       <= depth_in;
      lvl_ff         <= lvl_in;
      point_ff       <= point_in;
      seed_ff        <= seed_in;
      hash_ff        <= hash_in;
      tblk_ff        <= tblk_in;
      aes_st_ff      <= aes_st_in;
      rk_ff          <= rk_in;
      pass_ff        <= pass_in;
      keep_ff        <= keep_in;
      cwlo_ff        <= cwlo_in;
      acc_ff         <= acc_in;
      share_ff       <= share_in;
      share_valid_ff <= share_valid_in;
   end

   `DCF_ASSERT_NXT(a_eval_start, clock, reset, req_accept && req_ch.kind == KIND_EVAL, state_ff == S_SEED0)
   `DCF_ASSERT_IMP(a_busy_no_rsp, clock, reset, state_ff != S_IDLE, !rsp_valid_ff)
   `DCF_ASSERT_IMP(a_lvl_bound, clock, reset, state_ff != S_IDLE, lvl_ff <= depth_ff)
   `DCF_ASSERT_IMP(a_rnd_range, clock, reset, state_ff == S_ENC, rnd_ff >= 4'd1 && rnd_ff <= 4'd10)
endmodule
`default_nettype wire

/* design/dcf_aes_round.sv */
// ----------------------------------------------------------------------------
// DCF AES round unit
// One AES-128 encryption round with its key schedule step.
// ----------------------------------------------------------------------------
`default_nettype none
module dcf_aes_round (
   input  wire dcf_pkg::block_type st_in,
   input  wire dcf_pkg::block_type rk_in,
   input  wire logic [3:0]         rnd,
   output dcf_pkg::block_type      st_out,
   output dcf_pkg::block_type      rk_out
);
   import dcf_pkg::*;

   block_type ss;
   block_type mixed;

   // expand key and run the round; the last round skips column mixing
   always_comb begin
      rk_out = key_next(rk_in, rnd);
      ss     = sub_shift(st_in);
      mixed  = (rnd == 4'(AES_ROUNDS)) ? ss : mix_cols(ss);
      st_out = mixed ^ rk_out;
   end
endmodule
`default_nettype wire

/* design/dcf_key_store.sv */
// ----------------------------------------------------------------------------
// DCF key store
// Key half-word memory and correction bit memory, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none
module dcf_key_store #(
   parameter int NWORDS = 130,
   parameter int WAW    = 8,
   parameter int NBITS  = 65,
   parameter int BAW    = 7
) (
   input  wire logic              clock,
   input  wire logic              word_wr_en,
   input  wire logic [WAW-1:0]    word_wr_addr,
   input  wire logic [63:0]       word_wr_data,
   input  wire logic [WAW-1:0]    word_rd_addr,
   output logic [63:0]            word_rd_data,
   input  wire logic              bit_wr_en,
   input  wire logic [BAW-1:0]    bit_wr_addr,
   input  wire logic              bit_wr_data,
   input  wire logic [BAW-1:0]    bit_rd_addr,
   output logic                   bit_rd_data
);
   logic [63:0] word_mem [0:NWORDS-1];
   logic        bit_mem  [0:NBITS-1];
   logic [63:0] word_rd_ff;
   logic        bit_rd_ff;

   // write and read the half-word memory
   always_ff @(posedge clock) begin
      if (word_wr_en) begin
         word_mem[word_wr_addr] <= word_wr_data;
      end
      word_rd_ff <= word_mem[word_rd_addr];
   end

   // write and read the correction bit memory
   always_ff @(posedge clock) begin
      if (bit_wr_en) begin
         bit_mem[bit_wr_addr] <= bit_wr_data;
      end
      bit_rd_ff <= bit_mem[bit_rd_addr];
   end

   assign word_rd_data = word_rd_ff;
   assign bit_rd_data  = bit_rd_ff;
endmodule
`default_nettype wire

/* bench/dcf_single_point_eval_tb.sv */
// ----------------------------------------------------------------------------
// DCF single point evaluator testbench
// Loads a full key, then mixes key loads, correction bit loads, unused kinds and
// point evaluations over several tree depths. Each result is checked against a
// bit-accurate AES-based tree walk kept inside the bench. Both channels idle.
// ----------------------------------------------------------------------------
`default_nettype none
module dcf_single_point_eval_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dcf_pkg::*;

   localparam int NUM_WORDS = 2 * (MAX_DEPTH_DEF + 1);
   localparam int NUM_BITS  = MAX_DEPTH_DEF + 1;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WIDX_W-1:0]  word_index;
      logic [HALF_W-1:0]  key_half;
      logic [LEVEL_W-1:0] level;
      logic               correction_bit;
      logic [POINT_W-1:0] point;
   } req_item_t;

   typedef struct packed {
      logic [SHARE_W-1:0] share;
      logic               share_valid;
   } share_result_t;

   logic clock;
   logic reset;

   dcf_req_if req_bus ();
   dcf_rsp_if rsp_bus ();
   dcf_csr_if csr_bus ();

   dcf_single_point_eval u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // bench copy of the key store and the depth register
   logic [HALF_W-1:0]  key_store [NUM_WORDS];
   logic               corr_bits [NUM_BITS];
   logic [DEPTH_W-1:0] depth_reg;

   req_item_t     pending_q [$];
   share_result_t share_expect_q [$];
   int            mismatches;
   int            evals_checked;
   int            results_checked;
   int            depth_settings;
   bit            stimulus_done;

   // ------------------------------------------------------------------------
   // AES-128 and tree walk predictor
   // ------------------------------------------------------------------------
   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes_fixed_key(input logic [7:0] kval,
                                                  input logic [127:0] blk);
      logic [7:0] rk [16];
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] nw [4];
      logic [7:0] rc [10];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] res;
      rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      for (int i = 0; i < 16; i++) begin
         rk[i] = (i == 0) ? kval : 8'h00;
         st[i] = blk[8*i +: 8] ^ rk[i];
      end
      for (int r = 1; r <= 10; r++) begin
         // advance the round key
         nw[0] = SBOX[rk[13]] ^ rc[r-1];
         nw[1] = SBOX[rk[14]];
         nw[2] = SBOX[rk[15]];
         nw[3] = SBOX[rk[12]];
         for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ nw[i];
         for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
               tmp[k+4*c] = SBOX[st[k + 4*((c+k) & 3)]];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
               st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
               st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
               st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
         end else begin
            st = tmp;
         end
         for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) res[8*i +: 8] = st[i];
      return res;
   endfunction

   function automatic logic [7:0] walk_share(input logic [POINT_W-1:0] pt);
      int unsigned depth;
      logic [127:0] seed, hashed, tnext, vblk, cw;
      logic keep, tbit, dbit;
      logic [7:0] share;
      depth = (depth_reg > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : depth_reg;
      seed  = {key_store[1], key_store[0]};
      share = '0;
      for (int i = 0; i < depth; i++) begin
         keep   = pt[depth-1-i];
         hashed = {seed[127:2], 2'b00};
         tnext  = aes_fixed_key({7'd0, keep}, hashed) ^ hashed;
         vblk   = aes_fixed_key({6'd0, 1'b1, keep}, hashed) ^ hashed;
         cw     = {key_store[2*i+3], key_store[2*i+2]};
         tbit   = seed[0];
         share  = share ^ vblk[7:0] ^ {7'd0, tbit & corr_bits[i]};
         // correct the chosen child when the control bit is set
         if (tbit) begin
            dbit  = keep ? cw[0] : cw[1];
            tnext = tnext ^ {cw[127:2], 1'b0, dbit};
         end
         seed = tnext;
      end
      return share ^ {seed[7:2], 2'b00} ^ {7'd0, seed[0] & corr_bits[depth]};
   endfunction

   // apply one transaction to the bench state and return its result
   function automatic share_result_t apply_item(input req_item_t it);
      share_result_t r;
      r = '0;
      case (it.kind)
         KIND_LOAD_WORD: begin
            if (it.word_index < NUM_WORDS) key_store[it.word_index] = it.key_half;
         end
         KIND_LOAD_BIT: begin
            if (it.level < NUM_BITS) corr_bits[it.level] = it.correction_bit;
         end
         KIND_EVAL: begin
            r.share       = walk_share(it.point);
            r.share_valid = 1'b1;
            evals_checked++;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int unsigned idle_len();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(3, 1);
      return $urandom_range(80, 10);
   endfunction

   function automatic req_item_t noise_item(input logic [KIND_W-1:0] kind);
      req_item_t it;
      it.kind           = kind;
      it.word_index     = WIDX_W'($urandom);
      it.key_half       = {$urandom, $urandom};
      it.level          = LEVEL_W'($urandom);
      it.correction_bit = 1'($urandom);
      it.point          = {$urandom, $urandom};
      return it;
   endfunction

   task automatic push_word(input int idx, input logic [HALF_W-1:0] val);
      req_item_t it;
      it            = noise_item(KIND_LOAD_WORD);
      it.word_index = WIDX_W'(idx);
      it.key_half   = val;
      pending_q.push_back(it);
   endtask

   task automatic push_bit(input int lvl, input logic b);
      req_item_t it;
      it                = noise_item(KIND_LOAD_BIT);
      it.level          = LEVEL_W'(lvl);
      it.correction_bit = b;
      pending_q.push_back(it);
   endtask

   task automatic push_eval(input logic [POINT_W-1:0] pt);
      req_item_t it;
      it       = noise_item(KIND_EVAL);
      it.point = pt;
      pending_q.push_back(it);
   endtask

   // write every slot so no evaluation touches an unwritten entry
   task automatic push_full_key();
      for (int i = 0; i < NUM_WORDS; i++) push_word(i, {$urandom, $urandom});
      for (int i = 0; i < NUM_BITS; i++) push_bit(i, 1'($urandom));
   endtask

   task automatic push_random_items(input int count);
      int unsigned p;
      for (int n = 0; n < count; n++) begin
         p = $urandom_range(99);
         if (p < 40) push_eval({$urandom, $urandom});
         else if (p < 68) push_word($urandom_range(99) < 90 ? $urandom_range(NUM_WORDS-1)
                                    : $urandom_range(255, NUM_WORDS), {$urandom, $urandom});
         else if (p < 90) push_bit($urandom_range(99) < 90 ? $urandom_range(NUM_BITS-1)
                                   : $urandom_range(127, NUM_BITS), 1'($urandom));
         else pending_q.push_back(noise_item(KIND_UNUSED));
      end
   endtask

   task automatic wait_idle();
      while (pending_q.size() != 0 || share_expect_q.size() != 0 || req_bus.valid)
         @(posedge clock);
   endtask

   task automatic write_depth(input logic [DEPTH_W-1:0] d);
      @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.tree_depth <= d;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      depth_reg = d;
      depth_settings++;
      csr_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Clock, reset, limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Timeout with %0d results still expected", share_expect_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver: hold until accepted, then pop and predict
   // ------------------------------------------------------------------------
   int unsigned req_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid && req_bus.ready) begin
            share_expect_q.push_back(apply_item(pending_q.pop_front()));
         end
         if (req_gap > 0) begin
            req_gap       <= req_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_bus.valid          <= 1'b1;
            req_bus.kind           <= pending_q[0].kind;
            req_bus.word_index     <= pending_q[0].word_index;
            req_bus.key_half       <= pending_q[0].key_half;
            req_bus.level          <= pending_q[0].level;
            req_bus.correction_bit <= pending_q[0].correction_bit;
            req_bus.point          <= pending_q[0].point;
            req_gap                <= idle_len();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: compare against the oldest expectation, stall randomly
   // ------------------------------------------------------------------------
   int unsigned rsp_stall;
   share_result_t exp_r;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (share_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result share=%h share_valid=%b",
                           rsp_bus.share, rsp_bus.share_valid);
            end else begin
               exp_r = share_expect_q.pop_front();
               if (rsp_bus.share !== exp_r.share ||
                   rsp_bus.share_valid !== exp_r.share_valid) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected share=%h valid=%b, got share=%h valid=%b",
                              exp_r.share, exp_r.share_valid,
                              rsp_bus.share, rsp_bus.share_valid);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall     <= rsp_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_stall     <= idle_len();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: full key, directed cases, then random phases over depths
   // ------------------------------------------------------------------------
   logic [DEPTH_W-1:0] depth_plan [10];

   initial begin
      depth_plan = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd42, 7'd5, 7'd85, 7'd16, 7'd3, 7'd64};
      mismatches      = 0;
      evals_checked   = 0;
      results_checked = 0;
      depth_settings  = 0;
      stimulus_done   = 0;
      depth_reg       = DEPTH_W'(DEPTH_RESET);
      for (int i = 0; i < NUM_WORDS; i++) key_store[i] = '0;
      for (int i = 0; i < NUM_BITS; i++) corr_bits[i] = 1'b0;

      req_bus.valid          = 1'b0;
      req_bus.kind           = KIND_LOAD_WORD;
      req_bus.word_index     = '0;
      req_bus.key_half       = '0;
      req_bus.level          = '0;
      req_bus.correction_bit = 1'b0;
      req_bus.point          = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.tree_depth     = '0;

      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes at reset depth, out-of-range slots, unused kind
      push_full_key();
      push_eval('0);
      push_eval('1);
      push_eval(64'h8000_0000_0000_0000);
      push_eval(64'h5555_5555_5555_5555);
      push_word(0, '1);
      push_word(1, '0);
      push_word(NUM_WORDS, '1);
      push_word(255, '1);
      push_bit(NUM_BITS, 1'b1);
      push_bit(127, 1'b1);
      push_bit(MAX_DEPTH_DEF, 1'b1);
      push_eval(64'hAAAA_AAAA_AAAA_AAAA);
      pending_q.push_back(noise_item(KIND_UNUSED));
      push_eval('1);
      wait_idle();

      // random phases, one depth setting each
      foreach (depth_plan[p]) begin
         write_depth(depth_plan[p]);
         push_eval('0);
         push_eval('1);
         push_random_items(70);
         wait_idle();
      end

      stimulus_done = 1;
      repeat (20) @(posedge clock);
      $display("Covered %0d results (%0d evaluations) over %0d depth settings",
               results_checked, evals_checked, depth_settings + 1);
      $display("Mismatches or stray results: %0d", mismatches);
      if (mismatches == 0 && share_expect_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* dcf_single_point_eval.f */
+incdir+design
design/dcf_pkg.sv
design/dcf_req_if.sv
design/dcf_rsp_if.sv
design/dcf_csr_if.sv
design/dcf_aes_round.sv
design/dcf_key_store.sv
design/dcf_single_point_eval.sv
bench/dcf_single_point_eval_tb.sv
